// ----- src/lbw_pkg.sv -----
// ----------------------------------------------------------------------------
// lbw_pkg
// Shared types and constants for the 3x3 sliding window line buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbw_pkg;

	// pixel sample
	localparam int PIXEL_W = 8;
	typedef logic [PIXEL_W-1:0] pixel_t;

	// configuration register widths and reset values
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_INDEX_W  = 2;
	localparam int ROW_W        = HEIGHT_REG_W;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd1024;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// one line store entry: the column of both stored rows
	typedef struct packed {
		pixel_t older;
		pixel_t newer;
	} line_pair_t;

	// 3x3 window, entry 0 top left to entry 8 bottom right, row by row
	typedef pixel_t [8:0] window_t;

endpackage : lbw_pkg

`default_nettype wire

// ----- src/lbw_pix_if.sv -----
// ----------------------------------------------------------------------------
// lbw_pix_if
// Input pixel channel: valid/ready handshake with pixel and advance flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbw_pix_if import lbw_pkg::*;;

	logic   valid;
	logic   ready;
	pixel_t pixel;
	logic   advance;

	modport source (output valid, output pixel, output advance, input ready);
	modport sink   (input valid, input pixel, input advance, output ready);

endinterface : lbw_pix_if

`default_nettype wire

// ----- src/lbw_win_if.sv -----
// ----------------------------------------------------------------------------
// lbw_win_if
// Output window channel: valid/ready handshake with nine pixels and a flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbw_win_if import lbw_pkg::*;;

	logic   valid;
	logic   ready;
	pixel_t top_left;
	pixel_t top_mid;
	pixel_t top_right;
	pixel_t mid_left;
	pixel_t center;
	pixel_t mid_right;
	pixel_t bottom_left;
	pixel_t bottom_mid;
	pixel_t bottom_right;
	logic   window_valid;

	modport source (
		output valid, input ready,
		output top_left, output top_mid, output top_right,
		output mid_left, output center, output mid_right,
		output bottom_left, output bottom_mid, output bottom_right,
		output window_valid
	);
	modport sink (
		input valid, output ready,
		input top_left, input top_mid, input top_right,
		input mid_left, input center, input mid_right,
		input bottom_left, input bottom_mid, input bottom_right,
		input window_valid
	);

endinterface : lbw_win_if

`default_nettype wire

// ----- src/lbw_line_store.sv -----
// ----------------------------------------------------------------------------
// lbw_line_store
// Two stored image rows in one synchronous memory, one read and one write
// port, with a fill count standing in for reset and same-entry forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module lbw_line_store import lbw_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [CW-1:0] rd_addr,
	input  wire logic          wr_en,
	input  wire logic [CW-1:0] wr_addr,
	input  wire line_pair_t    wr_data,
	output line_pair_t         rd_data
);

	line_pair_t mem [MAX_WIDTH];

	line_pair_t    mem_rd_q;
	line_pair_t    fwd_data_q;
	logic          fwd_hit_q;
	logic          blank_q;
	logic [CW:0]   fill_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// forwarding of a write to the entry being read in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	// columns are written in order from zero, so the written entries form a prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			fwd_hit_q <= 1'b0;
			blank_q   <= 1'b1;
		end else begin
			if (wr_en && ({1'b0, wr_addr} == fill_q)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (rd_en) begin
				fwd_hit_q <= wr_en && (wr_addr == rd_addr);
				blank_q   <= !({1'b0, rd_addr} < fill_q);
			end
		end
	end

	// read data: forwarded, reset value or memory
	always_comb begin
		priority if (fwd_hit_q) begin
			rd_data = fwd_data_q;
		end else if (blank_q) begin
			rd_data = '0;
		end else begin
			rd_data = mem_rd_q;
		end
	end

endmodule : lbw_line_store

`default_nettype wire

// ----- src/lbw_raster.sv -----
// ----------------------------------------------------------------------------
// lbw_raster
// Image size registers and the raster row and column counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lbw_raster import lbw_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   step,
	output logic [CW-1:0]               col,
	output logic                        win_ok
);

	localparam int EW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CW-1:0]           col_q;
	logic [ROW_W-1:0]        row_q;
	logic [EW-1:0]           width_ext;
	logic [CW-1:0]           col_last;
	logic [ROW_W-1:0]        row_last;

	// last column and last row of the effective image size
	always_comb begin
		width_ext = EW'(width_q);
		priority if (width_q == '0) begin
			col_last = '0;
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(width_ext - 1'b1);
		end
		if (height_q == '0) begin
			row_last = '0;
		end else begin
			row_last = height_q - 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[WIDTH_REG_W-1:0];
			end else if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[HEIGHT_REG_W-1:0];
			end
		end
	end

	// raster position, wrapping at end of row and end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_q >= col_last) begin
				col_q <= '0;
				if (row_q >= row_last) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign col    = col_q;
	assign win_ok = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));

endmodule : lbw_raster

`default_nettype wire

// ----- src/line_buffer_window_3x3.sv -----
// ----------------------------------------------------------------------------
// line_buffer_window_3x3
// 3x3 sliding window over a raster pixel stream, two rows in a line store.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the window output stalls, and returns one
// window per pixel: the transfer in reads the line store at the current column,
// then stage 1 writes it back and loads the output register. That rate is set
// by the single read port and single write port of the line store. Pixels
// with advance low return the current window and change nothing. window_valid
// reflects row and column before the pixel. The line store holds no reset
// sweep: a fill count marks the columns written since reset and the others
// read as zero, so the block is ready right after reset. The user must write
// image_width and image_height only while the block idles; it is not enforced.
`default_nettype none

module line_buffer_window_3x3 import lbw_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	lbw_pix_if.sink                     pix,
	lbw_win_if.source                   win,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          accept;
	logic          s1_move;
	logic [CW-1:0] col;
	logic          win_ok;

	logic          s1_valid_q;
	pixel_t        pix_s1;
	logic          adv_s1;
	logic [CW-1:0] col_s1;
	logic          ok_s1;

	line_pair_t    rd_data;
	line_pair_t    wr_data;
	window_t       window_q;
	window_t       window_next;

	logic          out_valid_q;
	window_t       win_s2;
	logic          ok_s2;

	// handshake
	assign accept    = pix.valid && pix.ready;
	assign s1_move   = s1_valid_q && (!out_valid_q || win.ready);
	assign pix.ready = !s1_valid_q || s1_move;

	lbw_raster #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept && pix.advance),
		.col       (col),
		.win_ok    (win_ok)
	);

	assign wr_data.older = rd_data.newer;
	assign wr_data.newer = pix_s1;

	lbw_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && pix.advance),
		.rd_addr (col),
		.wr_en   (s1_move && adv_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// stage 1: item waits for the line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix.pixel;
			adv_s1 <= pix.advance;
			col_s1 <= col;
			ok_s1  <= win_ok;
		end
	end

	// window shift with the new right column
	always_comb begin
		window_next = window_q;
		if (adv_s1) begin
			window_next[0] = window_q[1];
			window_next[1] = window_q[2];
			window_next[2] = rd_data.older;
			window_next[3] = window_q[4];
			window_next[4] = window_q[5];
			window_next[5] = rd_data.newer;
			window_next[6] = window_q[7];
			window_next[7] = window_q[8];
			window_next[8] = pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_move) begin
			window_q <= window_next;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (win.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			win_s2 <= window_next;
			ok_s2  <= ok_s1;
		end
	end

	assign win.valid        = out_valid_q;
	assign win.top_left     = win_s2[0];
	assign win.top_mid      = win_s2[1];
	assign win.top_right    = win_s2[2];
	assign win.mid_left     = win_s2[3];
	assign win.center       = win_s2[4];
	assign win.mid_right    = win_s2[5];
	assign win.bottom_left  = win_s2[6];
	assign win.bottom_mid   = win_s2[7];
	assign win.bottom_right = win_s2[8];
	assign win.window_valid = ok_s2;

endmodule : line_buffer_window_3x3

`default_nettype wire

// ----- tb/line_buffer_window_3x3_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_buffer_window_3x3_tb
// Self-checking bench for the 3x3 sliding window line buffer.
// ----------------------------------------------------------------------------
// A short opening table covers reset state, pixel extremes, held pixels and
// degenerate or oversized frame settings. Random frames follow, mostly small
// enough that the window fills. A local line store model predicts every
// window, and each output transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module line_buffer_window_3x3_tb;
	import lbw_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int TOTAL_ITEMS   = 550;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;

	// indexes past the two registers, which the block ignores
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		window_t px;
		logic    valid;
	} window_result_t;

	typedef struct packed {
		logic                   is_cfg;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
		pixel_t                 pixel;
		logic                   advance;
		logic                   has_fixed;
		window_result_t         fixed;
	} opening_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	lbw_pix_if pix_ch ();
	lbw_win_if win_ch ();

	line_buffer_window_3x3 #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.win      (win_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// model state
	pixel_t                  older_row [MAX_W];
	pixel_t                  newer_row [MAX_W];
	window_t                 win_regs;
	int                      row_cnt;
	int                      col_cnt;
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;

	window_result_t pending_windows [$];
	window_result_t fixed_window;
	logic           fixed_pending;
	int             errors;
	int             items_sent;
	logic           no_idle;
	int             idle_pct;

	string field_names [10] = '{"top_left", "top_mid", "top_right", "mid_left", "center",
		"mid_right", "bottom_left", "bottom_mid", "bottom_right", "window_valid"};

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	// window model: shift in one column, update line stores and counters
	task automatic slide_window(input pixel_t p, input logic adv, output window_result_t r);
		int     w;
		int     h;
		int     c;
		pixel_t from_older;
		pixel_t from_newer;
		r.valid = (row_cnt >= 2) && (col_cnt >= 2);
		if (adv) begin
			w = (width_reg == 0) ? 1 : ((int'(width_reg) > MAX_W) ? MAX_W : int'(width_reg));
			h = (height_reg == 0) ? 1 : int'(height_reg);
			c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
			from_older = older_row[c];
			from_newer = newer_row[c];
			win_regs[0] = win_regs[1];
			win_regs[1] = win_regs[2];
			win_regs[2] = from_older;
			win_regs[3] = win_regs[4];
			win_regs[4] = win_regs[5];
			win_regs[5] = from_newer;
			win_regs[6] = win_regs[7];
			win_regs[7] = win_regs[8];
			win_regs[8] = p;
			older_row[c] = from_newer;
			newer_row[c] = p;
			if (col_cnt >= w - 1) begin
				col_cnt = 0;
				row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
			end else begin
				col_cnt = col_cnt + 1;
			end
		end
		r.px = win_regs;
	endtask

	// monitor: register writes, pixel transfers in, window transfers out
	always @(posedge clk) begin : monitor
		window_result_t predicted;
		window_result_t want;
		window_result_t got;
		logic [7:0]     want_v;
		logic [7:0]     got_v;
		if (!arst_n) begin
			for (int i = 0; i < MAX_W; i++) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			win_regs = '0;
			row_cnt = 0;
			col_cnt = 0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_REG_W-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
					default: ;
				endcase
			end
			if (pix_ch.valid && pix_ch.ready) begin
				slide_window(pix_ch.pixel, pix_ch.advance, predicted);
				pending_windows.push_back(fixed_pending ? fixed_window : predicted);
			end
			if (win_ch.valid && win_ch.ready) begin
				got.px[0] = win_ch.top_left;
				got.px[1] = win_ch.top_mid;
				got.px[2] = win_ch.top_right;
				got.px[3] = win_ch.mid_left;
				got.px[4] = win_ch.center;
				got.px[5] = win_ch.mid_right;
				got.px[6] = win_ch.bottom_left;
				got.px[7] = win_ch.bottom_mid;
				got.px[8] = win_ch.bottom_right;
				got.valid = win_ch.window_valid;
				if (pending_windows.size() == 0) begin
					$display("%0t: window transfer with none expected, actual %h", $time, got);
					errors++;
				end else begin
					want = pending_windows.pop_front();
					for (int k = 0; k < 10; k++) begin
						want_v = (k < 9) ? want.px[k] : {7'd0, want.valid};
						got_v = (k < 9) ? got.px[k] : {7'd0, got.valid};
						if (want_v !== got_v) begin
							$display("%0t: %s expected %0d actual %0d",
								$time, field_names[k], want_v, got_v);
							errors++;
						end
					end
				end
			end
		end
	end

	// window sink: ready drops in short random bursts
	initial begin : window_sink
		int hold;
		hold = 0;
		win_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (no_idle) begin
				win_ch.ready = 1'b1;
			end else if (hold > 0) begin
				win_ch.ready = 1'b0;
				hold--;
			end else if ($urandom_range(0, 99) < 15) begin
				win_ch.ready = 1'b0;
				hold = $urandom_range(1, 5) - 1;
			end else begin
				win_ch.ready = 1'b1;
			end
		end
	end

	// one pixel transfer, entered and left at a falling edge
	task automatic send_pixel(input pixel_t p, input logic adv, input logic has_fixed,
			input window_result_t fixed);
		if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
			pix_ch.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.pixel = p;
		pix_ch.advance = adv;
		fixed_pending = has_fixed;
		fixed_window = fixed;
		do @(posedge clk); while (!pix_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// stop sending until every expected window is out and the pipe is empty
	task automatic drain_windows();
		pix_ch.valid = 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		drain_windows();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		opening_row_t   opening [$];
		opening_row_t   row;
		window_result_t none;
		pixel_t         p;
		int             phase;
		int             count;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		pix_ch.advance = 1'b0;
		fixed_pending = 1'b0;
		fixed_window = '0;
		errors = 0;
		items_sent = 0;
		no_idle = 1'b0;
		idle_pct = 25;
		none = '0;

		// opening table; fixed windows are packed bottom_right first, flag last
		// after reset: a held pixel returns the cleared window
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd0, 1'b0, 1'b1, {72'd0, 1'b0}});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd255, 1'b1, 1'b1,
			{8'd255, 64'd0, 1'b0}});
		// held pixel leaves the window alone
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd17, 1'b0, 1'b1,
			{8'd255, 64'd0, 1'b0}});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd0, 1'b1, 1'b1,
			{8'd0, 8'd255, 56'd0, 1'b0}});
		// shrink the frame with the column already on the new last column
		opening.push_back('{1'b1, REG_IMAGE_WIDTH, 12'd3, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b1, REG_IMAGE_HEIGHT, 12'd3, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd255, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd0, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd255, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd128, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd1, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd254, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'hAA, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'h55, 1'b0, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'h55, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd255, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd0, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd255, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd7, 1'b1, 1'b0, none});
		// zero width and height act as one
		opening.push_back('{1'b1, REG_IMAGE_WIDTH, 12'd0, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b1, REG_IMAGE_HEIGHT, 12'd0, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd200, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd31, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd99, 1'b1, 1'b0, none});
		// oversized width is clamped, spare indexes are ignored
		opening.push_back('{1'b1, REG_IMAGE_WIDTH, 12'hFFF, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b1, REG_IMAGE_HEIGHT, 12'hFFF, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b1, REG_SPARE_A, 12'hFFF, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b1, REG_SPARE_B, 12'd0, 8'd0, 1'b0, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd64, 1'b1, 1'b0, none});
		opening.push_back('{1'b0, REG_IMAGE_WIDTH, 12'd0, 8'd65, 1'b0, 1'b0, none});

		// reset
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening[i]) begin
			row = opening[i];
			if (row.is_cfg)
				write_register(row.index, row.data);
			else
				send_pixel(row.pixel, row.advance, row.has_fixed, row.fixed);
		end

		// random frames
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			phase++;
			case ($urandom_range(0, 11))
				0:       write_register(REG_IMAGE_WIDTH, 12'd0);
				1:       write_register(REG_IMAGE_WIDTH, 12'd1);
				2:       write_register(REG_IMAGE_WIDTH, 12'd2);
				3:       write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_W));
				4:       write_register(REG_IMAGE_WIDTH, 12'h7FF);
				default: write_register(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(3, 10)));
			endcase
			case ($urandom_range(0, 9))
				0:       write_register(REG_IMAGE_HEIGHT, 12'd0);
				1:       write_register(REG_IMAGE_HEIGHT, 12'd1);
				2:       write_register(REG_IMAGE_HEIGHT, 12'd2);
				3:       write_register(REG_IMAGE_HEIGHT, 12'hFFF);
				default: write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(3, 6)));
			endcase
			if ($urandom_range(0, 7) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom_range(0, 4095)));
			idle_pct = $urandom_range(0, 3) * 12;
			if (items_sent >= TOTAL_ITEMS - 70)
				no_idle = 1'b1;
			count = $urandom_range(30, 70);
			if (count > TOTAL_ITEMS - items_sent)
				count = TOTAL_ITEMS - items_sent;
			for (int i = 0; i < count; i++) begin
				// hold the sender until the window stream catches up
				if (phase == 3 && i == count / 2)
					drain_windows();
				case ($urandom_range(0, 7))
					0:       p = 8'd0;
					1:       p = 8'd255;
					default: p = pixel_t'($urandom_range(0, 255));
				endcase
				send_pixel(p, $urandom_range(0, 99) < 85, 1'b0, none);
			end
		end

		// end of run
		pix_ch.valid = 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule : line_buffer_window_3x3_tb
